### sv/key_click_gesture_detector_unit_macros.svh
// -----------------------------------------------------------------------------
// key_click_gesture_detector_unit_macros.svh
// Assertion helpers shared by the key click gesture detector RTL.
// -----------------------------------------------------------------------------
`ifndef KEY_CLICK_GESTURE_DETECTOR_UNIT_MACROS_SVH
`define KEY_CLICK_GESTURE_DETECTOR_UNIT_MACROS_SVH

// Check that cond_a implies cond_b on the same clock edge, outside reset.
`define KCG_ASSERT_IMPLIES(lbl, cond_a, cond_b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |-> (cond_b)) else $error(msg);

// Check that cond never holds, outside reset.
`define KCG_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        !(cond)) else $error(msg);

`endif

### sv/kcg_pkg.sv
// -----------------------------------------------------------------------------
// kcg_pkg
// Shared types and constants of the key click gesture detector.
// -----------------------------------------------------------------------------
package kcg_pkg;

    localparam int TIME_W    = 16;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_TIMEOUT = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTV    = 8'd4;

    // Reset values of the configuration registers, in milliseconds
    localparam logic [TIME_W-1:0] RST_SCAN_PERIOD    = 16'd20;
    localparam logic [TIME_W-1:0] RST_LONG_PRESS     = 16'd1000;
    localparam logic [TIME_W-1:0] RST_DOUBLE_WINDOW  = 16'd300;
    localparam logic [TIME_W-1:0] RST_SECOND_TIMEOUT = 16'd1000;
    localparam logic [TIME_W-1:0] RST_REPEAT_INTV    = 16'd200;

    typedef logic [TIME_W-1:0] t_time;

    typedef struct packed {
        t_time scan_period_ms;
        t_time long_press_ms;
        t_time double_click_window_ms;
        t_time second_press_timeout_ms;
        t_time repeat_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic double_click_event;
        logic click_event;
        logic repeat_event;
        logic long_press_event;
        logic up_event;
        logic down_event;
    } t_events;

endpackage

### sv/kcg_cfg_regs.sv
// -----------------------------------------------------------------------------
// kcg_cfg_regs
// Timing configuration registers, written through the configuration channel.
// -----------------------------------------------------------------------------
module kcg_cfg_regs
    import kcg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Write the addressed register, drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_period_ms          <= RST_SCAN_PERIOD;
            r_cfg.long_press_ms           <= RST_LONG_PRESS;
            r_cfg.double_click_window_ms  <= RST_DOUBLE_WINDOW;
            r_cfg.second_press_timeout_ms <= RST_SECOND_TIMEOUT;
            r_cfg.repeat_interval_ms      <= RST_REPEAT_INTV;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCAN_PERIOD:    r_cfg.scan_period_ms          <= i_cfg_data;
                CFG_LONG_PRESS:     r_cfg.long_press_ms           <= i_cfg_data;
                CFG_DOUBLE_WINDOW:  r_cfg.double_click_window_ms  <= i_cfg_data;
                CFG_SECOND_TIMEOUT: r_cfg.second_press_timeout_ms <= i_cfg_data;
                CFG_REPEAT_INTV:    r_cfg.repeat_interval_ms      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/kcg_phase_fsm.sv
// -----------------------------------------------------------------------------
// kcg_phase_fsm
// Key phase machine: countdown, edge detection and gesture event decode.
// -----------------------------------------------------------------------------
module kcg_phase_fsm
    import kcg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_pin_level,
    input  t_cfg    i_cfg,
    output t_events o_events
);

    typedef enum logic [2:0] {
        PH_FREE     = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_RELEASED = 3'd2,
        PH_LONG     = 3'd3,
        PH_WAIT2    = 3'd4
    } t_phase;

    t_phase  r_phase;
    t_phase  n_phase;
    logic    r_was_pressed;
    t_time   r_remaining;
    t_time   n_remaining;
    t_time   w_counted;
    logic    w_pressed;
    logic    w_expired;
    t_events w_ev;

    assign w_pressed = ~i_pin_level;

    // Saturating countdown by one scan period
    assign w_counted = (r_remaining > i_cfg.scan_period_ms)
                     ? t_time'(r_remaining - i_cfg.scan_period_ms) : '0;
    assign w_expired = (w_counted == '0);

    // Edges, then phase transitions
    always_comb begin
        w_ev             = '0;
        w_ev.down_event  = ~r_was_pressed & w_pressed;
        w_ev.up_event    = r_was_pressed & ~w_pressed;
        n_phase          = r_phase;
        n_remaining      = w_counted;
        unique case (r_phase)
            PH_PRESSED: begin
                if (!w_pressed) begin
                    n_remaining = i_cfg.double_click_window_ms;
                    n_phase     = PH_RELEASED;
                end else if (w_expired) begin
                    w_ev.long_press_event = 1'b1;
                    n_remaining           = i_cfg.repeat_interval_ms;
                    n_phase               = PH_LONG;
                end
            end
            PH_RELEASED: begin
                if (w_pressed) begin
                    n_remaining = i_cfg.second_press_timeout_ms;
                    n_phase     = PH_WAIT2;
                end else if (w_expired) begin
                    w_ev.click_event = 1'b1;
                    n_phase          = PH_FREE;
                end
            end
            PH_LONG: begin
                if (!w_pressed) begin
                    n_phase = PH_FREE;
                end else if (w_expired) begin
                    w_ev.repeat_event = 1'b1;
                    n_remaining       = i_cfg.repeat_interval_ms;
                end
            end
            PH_WAIT2: begin
                if (!w_pressed) begin
                    w_ev.double_click_event = 1'b1;
                    n_phase                 = PH_FREE;
                end else if (w_expired) begin
                    // no reload: the running count carries into long press
                    n_phase = PH_LONG;
                end
            end
            default: begin
                if (w_pressed) begin
                    n_remaining = i_cfg.long_press_ms;
                    n_phase     = PH_PRESSED;
                end else begin
                    n_phase = PH_FREE;
                end
            end
        endcase
    end

    // Advance the state on each processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_FREE;
            r_was_pressed <= 1'b0;
            r_remaining   <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_was_pressed <= w_pressed;
            r_remaining   <= n_remaining;
        end
    end

    assign o_events = w_ev;

endmodule

### sv/key_click_gesture_detector_unit.sv
// -----------------------------------------------------------------------------
// key_click_gesture_detector_unit
// Key gesture detector: turns sampled key pin ticks into gesture event flags.
// -----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per scan tick, tdata[0] is the sampled active-low
//   key pin. Master stream: one beat per tick with six event flags.
//   Configuration channel: index 0..4 selects scan period, long-press time,
//   double-click window, second-press timeout and repeat interval (16-bit ms);
//   other indexes are ignored. Write only while the stream is idle.
//   Path: an accepted tick is held in the input register, then its events
//   are registered in the result register when the phase machine steps.
//   Throughput: one tick per cycle unless the master stalls; the phase machine
//   steps once per beat, and the input register holds the next tick while a result waits.
//   Reset: phase free, key released, countdown zero, registers to defaults,
//   both stream sides empty.
//   Stall: when the master side holds tready low, the result beat holds, the
//   input register fills, then tready on the slave side drops until the
//   result is taken.
// -----------------------------------------------------------------------------
module key_click_gesture_detector_unit
    import kcg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // [0] pin_level, [7:1] zero
    // master stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [0] down_event, [1] up_event, [2] long_press_event, [3] repeat_event,
    // [4] click_event, [5] double_click_event, [7:6] zero
    output logic [7:0]           o_m_axis_tdata,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

`include "key_click_gesture_detector_unit_macros.svh"

    t_cfg    w_cfg;
    t_events w_events;
    logic    r_in_valid;
    logic    r_in_pin;
    logic    r_out_valid;
    t_events r_out_events;
    logic    w_step;
    logic    w_in_take;

    assign o_cfg_ready = 1'b1;

    kcg_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Process the held tick when the result slot is free or being drained
    assign w_step          = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | w_step;
    assign w_in_take       = i_s_axis_tvalid & o_s_axis_tready;

    kcg_phase_fsm u_phase_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_pin_level (r_in_pin),
        .i_cfg       (w_cfg),
        .o_events    (w_events)
    );

    // Input register: capture the incoming beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_pin <= i_s_axis_tdata[0];
        end
    end

    // Result register: load on a step, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_events <= w_events;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_events};

    // A tick is never both a press and a release edge
    `KCG_ASSERT_NEVER(a_edge_excl, r_out_valid && r_out_events.down_event && r_out_events.up_event, "down and up on one tick")
    // A double click completes on the release of the second press
    `KCG_ASSERT_IMPLIES(a_dbl_up, r_out_valid && r_out_events.double_click_event, r_out_events.up_event, "double click without release edge")
    // A long press fires only while the key stays held
    `KCG_ASSERT_IMPLIES(a_lp_held, r_out_valid && r_out_events.long_press_event, !r_out_events.down_event && !r_out_events.up_event, "long press on an edge tick")

endmodule
